// File: src/knn_inverse_distance_weights_unit_defines.svh
// Assertion macros for the inverse-distance weights unit.
`ifndef KNN_INVERSE_DISTANCE_WEIGHTS_UNIT_DEFINES_SVH
`define KNN_INVERSE_DISTANCE_WEIGHTS_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define KIDW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define KIDW_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define KIDW_ASSERT(lbl, clk, rstn, prop)
`define KIDW_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// File: src/kidw_pkg.sv
// Shared types and constants of the inverse-distance weights unit.
`timescale 1ns / 1ps
`default_nettype none
package kidw_pkg;
  localparam int MaxSources   = 65536;
  localparam int MaxNeighbors = 8;
  localparam int CoordBits    = 18;
  localparam int IndexW       = 16;
  localparam int WeightW      = 17;
  localparam int CountW       = 4;
  localparam logic [3:0] NeighborReset = 4'd5;
  localparam logic [1:0] ActClear = 2'd0;
  localparam logic [1:0] ActLoad  = 2'd1;
  localparam logic [1:0] ActQuery = 2'd2;
endpackage
`default_nettype wire

// File: src/kidw_req_if.sv
// Request and result channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface kidw_req_if #(parameter int CW = 18);
  logic          valid;
  logic          ready;
  logic [1:0]    action;
  logic [CW-1:0] coord_x;
  logic [CW-1:0] coord_y;
  logic [CW-1:0] coord_z;
  modport source (output valid, action, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, action, coord_x, coord_y, coord_z, output ready);
endinterface

interface kidw_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] source_index;
  logic [16:0] weight;
  logic        last;
  modport source (output valid, source_index, weight, last, input ready);
  modport sink (input valid, source_index, weight, last, output ready);
endinterface
`default_nettype wire

// File: src/kidw_divider.sv
// Shared restoring divider and square root, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module kidw_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        sqrt_i,
  input  wire logic [63:0] num_i,
  input  wire logic [63:0] den_i,
  output logic             busy_o,
  output logic [63:0]      quo_o
);
  logic [63:0] num_q, num_d, quo_q, quo_d, den_q, den_d;
  logic [65:0] rem_q, rem_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        sqrt_q, sqrt_d;
  logic [65:0] trial;
  logic [65:0] sh;

  // One step: shift in the next numerator bits and try a subtract.
  always_comb begin
    num_d = num_q; quo_d = quo_q; rem_d = rem_q; cnt_d = cnt_q;
    den_d = den_q; sqrt_d = sqrt_q; sh = '0; trial = '0;
    if (start_i) begin
      num_d = num_i; den_d = den_i; sqrt_d = sqrt_i; quo_d = '0; rem_d = '0;
      cnt_d = sqrt_i ? 7'd32 : 7'd64;
    end else if (cnt_q != 7'd0) begin
      if (sqrt_q) begin
        sh = {rem_q[63:0], num_q[63:62]};
        trial = sh - {quo_q, 2'b01};
        num_d = {num_q[61:0], 2'b00};
      end else begin
        sh = {rem_q[64:0], num_q[63]};
        trial = sh - {2'b00, den_q};
        num_d = {num_q[62:0], 1'b0};
      end
      if (!trial[65]) begin
        rem_d = trial; quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = sh; quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d; sqrt_q <= sqrt_d;
  end

  assign busy_o = (cnt_q != 7'd0);
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

// File: src/knn_inverse_distance_weights_unit.sv
// Top level: k-nearest inverse-distance weights over a stored point set.
// Clear and load complete when the request is taken. A query reads, squares, sums and inserts each stored point,
// then takes the root and inverse of each neighbor in the shared bit-serial
// divide/root unit, then a normalizing divide for each result, which is held
// valid until ready. No request is taken while a query runs.
// Reset empties the store and sets the neighbor count to five; memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "knn_inverse_distance_weights_unit_defines.svh"
module knn_inverse_distance_weights_unit #(
  parameter int MAX_SOURCES   = kidw_pkg::MaxSources,
  parameter int MAX_NEIGHBORS = kidw_pkg::MaxNeighbors,
  parameter int COORD_BITS    = kidw_pkg::CoordBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [kidw_pkg::CountW-1:0] cfg_wdata_i,
  kidw_req_if.sink   req,
  kidw_res_if.source res
);
  import kidw_pkg::*;
  localparam int AW = $clog2(MAX_SOURCES);
  localparam int TW = AW + 1;
  localparam int KW = $clog2(MAX_NEIGHBORS + 1);
  localparam int LW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int DW = 2 * COORD_BITS + 3;
  localparam int SH = 60 - 2 * COORD_BITS;
  localparam logic [63:0] WNum = 64'd1 << (SH / 2 + 32);

  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_SQ = 4'd2, S_ADD = 4'd3,
    S_INS = 4'd4, S_ROOT = 4'd5, S_RW = 4'd6, S_INV = 4'd7, S_IW = 4'd8,
    S_NRM = 4'd9, S_NW = 4'd10, S_OUT = 4'd11;

  logic [3:0] st_q;
  logic [CountW-1:0] ncfg_q;
  logic [TW-1:0] total_q, scan_q;
  logic [KW-1:0] k_q, cnt_q, zeros_q;
  logic [LW-1:0] i_q;
  logic signed [COORD_BITS-1:0] px_q, py_q, pz_q;
  logic [3*COORD_BITS-1:0] mem [MAX_SOURCES];
  logic [3*COORD_BITS-1:0] rd_q;
  logic [COORD_BITS:0] ax_q, ay_q, az_q;
  logic [2*COORD_BITS+1:0] sqx, sqy, sqz;
  logic [DW-1:0] d2_q;
  logic [TW-1:0] idx_q;
  logic [DW-1:0] bd_q [MAX_NEIGHBORS];
  logic [TW-1:0] bi_q [MAX_NEIGHBORS];
  logic [63:0] w_q [MAX_NEIGHBORS];
  logic [63:0] wsum_q;
  logic [WeightW-1:0] wt_q;
  logic dv_start;
  logic dv_sqrt, dv_busy;
  logic [63:0] dv_num, dv_den, dv_quo;
  logic [KW-1:0] keff;
  logic acc;

  function automatic logic [COORD_BITS:0] absdiff(input logic [COORD_BITS-1:0] a,
                                                  input logic [COORD_BITS-1:0] b);
    logic signed [COORD_BITS:0] d;
    d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    return d[COORD_BITS] ? $unsigned(-d) : $unsigned(d);
  endfunction

  assign acc = req.valid && req.ready;
  assign req.ready = (st_q == S_IDLE);

  // Clip the neighbor count to its legal range and the store size.
  always_comb begin
    keff = (ncfg_q == '0) ? KW'(1) :
           (32'(ncfg_q) > MAX_NEIGHBORS) ? KW'(MAX_NEIGHBORS) : KW'(ncfg_q);
    if (TW'(keff) > total_q) keff = KW'(total_q);
  end

  kidw_divider u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .sqrt_i(dv_sqrt),
    .num_i(dv_num), .den_i(dv_den), .busy_o(dv_busy), .quo_o(dv_quo)
  );

  // Operand selection for the shared unit.
  always_comb begin
    dv_start = 1'b0; dv_sqrt = 1'b0; dv_num = '0; dv_den = 64'd1;
    case (st_q)
      S_ROOT: begin
        dv_start = 1'b1; dv_sqrt = 1'b1; dv_num = 64'(bd_q[i_q]) << SH;
      end
      S_INV: begin
        dv_start = 1'b1; dv_num = WNum; dv_den = dv_quo;
      end
      S_NRM: begin
        dv_start = 1'b1;
        // Points at zero distance split the whole weight evenly.
        if (zeros_q != '0) begin
          dv_num = (bd_q[i_q] == '0) ? 64'd65536 + 64'(zeros_q >> 1) : 64'd0;
          dv_den = 64'(zeros_q);
        end else begin
          dv_num = (w_q[i_q] << 16) + (wsum_q >> 1); dv_den = wsum_q;
        end
      end
      default: ;
    endcase
  end

  // Store writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (acc && req.action == ActLoad && total_q < TW'(MAX_SOURCES))
      mem[total_q[AW-1:0]] <= {req.coord_x, req.coord_y, req.coord_z};
    rd_q <= mem[scan_q[AW-1:0]];
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ncfg_q <= NeighborReset; total_q <= '0; res.valid <= 1'b0;
      scan_q <= '0; cnt_q <= '0; k_q <= '0; zeros_q <= '0; i_q <= '0;
    end else begin
      if (cfg_we_i) ncfg_q <= cfg_wdata_i;
      case (st_q)
        S_IDLE: if (acc) begin
          if (req.action == ActClear) total_q <= '0;
          else if (req.action == ActLoad) begin
            if (total_q < TW'(MAX_SOURCES)) total_q <= total_q + 1'b1;
          end else if (req.action == ActQuery && total_q != '0) begin
            k_q <= keff; cnt_q <= '0; scan_q <= '0; zeros_q <= '0; st_q <= S_RD;
          end
        end
        S_RD: st_q <= S_SQ;
        S_SQ: st_q <= S_ADD;
        S_ADD: st_q <= S_INS;
        S_INS: begin
          if (scan_q + 1'b1 == total_q) begin
            i_q <= '0; st_q <= S_ROOT;
          end else begin
            scan_q <= scan_q + 1'b1; st_q <= S_RD;
          end
          if (cnt_q != k_q) cnt_q <= cnt_q + 1'b1;
        end
        S_ROOT: begin
          if (bd_q[i_q] == '0) zeros_q <= zeros_q + 1'b1;
          st_q <= S_RW;
        end
        S_RW: if (!dv_busy) st_q <= S_INV;
        S_INV: st_q <= S_IW;
        S_IW: if (!dv_busy) begin
          if (32'(i_q) + 1 == 32'(k_q)) begin
            i_q <= '0; st_q <= S_NRM;
          end else begin
            i_q <= i_q + 1'b1; st_q <= S_ROOT;
          end
        end
        S_NRM: st_q <= S_NW;
        S_NW: if (!dv_busy) begin
          res.valid <= 1'b1; st_q <= S_OUT;
        end
        S_OUT: if (res.ready) begin
          res.valid <= 1'b0;
          if (32'(i_q) + 1 == 32'(k_q)) st_q <= S_IDLE;
          else begin
            i_q <= i_q + 1'b1; st_q <= S_NRM;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // Squares of the coordinate differences.
  assign sqx = ax_q * ax_q;
  assign sqy = ay_q * ay_q;
  assign sqz = az_q * az_q;

  // Datapath: distance pipeline, sorted insertion, weights.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      px_q <= req.coord_x; py_q <= req.coord_y; pz_q <= req.coord_z;
    end
    if (st_q == S_SQ) begin
      ax_q <= absdiff(rd_q[3*COORD_BITS-1 -: COORD_BITS], px_q);
      ay_q <= absdiff(rd_q[2*COORD_BITS-1 -: COORD_BITS], py_q);
      az_q <= absdiff(rd_q[COORD_BITS-1:0], pz_q);
      idx_q <= scan_q;
    end
    if (st_q == S_ADD) begin
      d2_q <= DW'(sqx) + DW'(sqy) + DW'(sqz);
    end
    if (st_q == S_INS) begin
      for (int j = 0; j < MAX_NEIGHBORS; j++) begin
        if (32'(j) < 32'(k_q)) begin
          if ((32'(j) < 32'(cnt_q) && bd_q[j] > d2_q) || 32'(j) == 32'(cnt_q)) begin
            if (j == 0 || !(32'(j) <= 32'(cnt_q) && bd_q[(j == 0) ? 0 : j-1] > d2_q)) begin
              bd_q[j] <= d2_q; bi_q[j] <= idx_q;
            end else begin
              bd_q[j] <= bd_q[(j == 0) ? 0 : j-1]; bi_q[j] <= bi_q[(j == 0) ? 0 : j-1];
            end
          end
        end
      end
    end
    if (st_q == S_ROOT && i_q == '0) wsum_q <= '0;
    if (st_q == S_IW && !dv_busy) begin
      w_q[i_q] <= (dv_quo == '0) ? 64'd0 : dv_quo;
      wsum_q <= wsum_q + dv_quo;
    end
    if (st_q == S_NW && !dv_busy) begin
      wt_q <= WeightW'(dv_quo);
    end
  end

  assign res.source_index = IndexW'(bi_q[i_q]);
  assign res.weight = wt_q;
  assign res.last = (32'(i_q) + 1 == 32'(k_q));

  `KIDW_ASSERT(a_ready_idle, clk_i, rst_ni, res.valid |-> !req.ready)
  `KIDW_ASSERT(a_total_max, clk_i, rst_ni, total_q <= TW'(MAX_SOURCES))
  `KIDW_ASSERT(a_k_le_total, clk_i, rst_ni, (st_q != S_IDLE) |-> (TW'(k_q) <= total_q))
endmodule
`default_nettype wire
